@@ sv/buffer_frame_replacement_unit_assert.svh @@
// Assertion macros for the buffer frame replacement unit
`ifndef BUFFER_FRAME_REPLACEMENT_UNIT_ASSERT_SVH
`define BUFFER_FRAME_REPLACEMENT_UNIT_ASSERT_SVH
`define BFR_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BFR_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ sv/bfr_pkg.sv @@
// Package of types and constants for the buffer frame replacement unit
`default_nettype none
package bfr_pkg;
    localparam int unsigned FRAMES_DEF     = 16;
    localparam int unsigned BLOCK_BITS_DEF = 24;

    typedef enum logic [1:0] {
        POL_LRU   = 2'd0,
        POL_MRU   = 2'd1,
        POL_CLOCK = 2'd2,
        POL_ALT   = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        KIND_REQ     = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_DIRTY   = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_MISS    = 2'd1,
        ST_PINNED  = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    localparam int unsigned PIN_W     = 8;
    localparam logic [PIN_W-1:0] PIN_MAX = '1;
endpackage
`default_nettype wire

@@ sv/bfr_if.sv @@
// Valid-ready channel interfaces for request, result and configuration transfers
`default_nettype none
interface bfr_req_if #(parameter int unsigned BLOCK_BITS = 24);
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [BLOCK_BITS-1:0] block_num;
    modport source (output valid, kind, block_num, input ready);
    modport sink   (input valid, kind, block_num, output ready);
endinterface

interface bfr_res_if #(parameter int unsigned BLOCK_BITS = 24);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [3:0]            frame;
    logic                  evict_valid;
    logic [BLOCK_BITS-1:0] victim_block;
    logic                  evict_dirty;
    modport source (output valid, status, frame, evict_valid, victim_block, evict_dirty,
                    input ready);
    modport sink   (input valid, status, frame, evict_valid, victim_block, evict_dirty,
                    output ready);
endinterface

interface bfr_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [4:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/bfr_frame_table.sv @@
// Per-frame state registers with a single indexed read and update port
`default_nettype none
module bfr_frame_table
    import bfr_pkg::*;
#(
    parameter int unsigned FRAMES     = FRAMES_DEF,
    parameter int unsigned BLOCK_BITS = BLOCK_BITS_DEF,
    localparam int unsigned FW        = $clog2(FRAMES)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [FW-1:0]         i_idx,
    output logic                       o_valid,
    output logic [BLOCK_BITS-1:0]      o_block,
    output logic [PIN_W-1:0]           o_pin,
    output logic                       o_dirty,
    output logic                       o_ref,
    output logic [FW-1:0]              o_age,
    input  wire logic                  i_we,
    input  wire logic                  i_valid,
    input  wire logic [BLOCK_BITS-1:0] i_block,
    input  wire logic [PIN_W-1:0]      i_pin,
    input  wire logic                  i_dirty,
    input  wire logic                  i_ref,
    input  wire logic [FW-1:0]         i_age
);
    logic                  r_valid [FRAMES];
    logic [BLOCK_BITS-1:0] r_block [FRAMES];
    logic [PIN_W-1:0]      r_pin   [FRAMES];
    logic                  r_dirty [FRAMES];
    logic                  r_ref   [FRAMES];
    logic [FW-1:0]         r_age   [FRAMES];

    assign o_valid = r_valid[i_idx];
    assign o_block = r_block[i_idx];
    assign o_pin   = r_pin[i_idx];
    assign o_dirty = r_dirty[i_idx];
    assign o_ref   = r_ref[i_idx];
    assign o_age   = r_age[i_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRAMES; k++) begin
                r_valid[k] <= 1'b0;
                r_block[k] <= '0;
                r_pin[k]   <= '0;
                r_dirty[k] <= 1'b0;
                r_ref[k]   <= 1'b0;
                r_age[k]   <= '0;
            end
        end else if (i_we) begin
            r_valid[i_idx] <= i_valid;
            r_block[i_idx] <= i_block;
            r_pin[i_idx]   <= i_pin;
            r_dirty[i_idx] <= i_dirty;
            r_ref[i_idx]   <= i_ref;
            r_age[i_idx]   <= i_age;
        end
    end
endmodule
`default_nettype wire

@@ sv/buffer_frame_replacement_unit.sv @@
// Top level of the buffer frame replacement unit: sequencer over the frame table
// Sequence: release and mark-dirty run a lookup; a hit runs a lookup and a rank update;
// a miss runs lookup, free search, clock sweep or age scan, rank drop, load and rank
// update. One frame table entry is visited per cycle.
// Throughput: one item at a time; the request channel is ready only when idle.
// Reset: synchronous, active low; clears all frames and clock hand, restores default configuration.
`default_nettype none
module buffer_frame_replacement_unit
    import bfr_pkg::*;
#(
    parameter int unsigned FRAMES     = FRAMES_DEF,
    parameter int unsigned BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bfr_req_if.sink   req,
    bfr_res_if.source res,
    bfr_cfg_if.sink   cfg
);
    localparam int unsigned FW = $clog2(FRAMES);
    localparam int unsigned NW = FW + 1;
    localparam int unsigned CW = NW + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FIND  = 9'b000000010,
        S_FREE  = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_CLOCK = 9'b000010000,
        S_DROP  = 9'b000100000,
        S_LOAD  = 9'b001000000,
        S_TOUCH = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_policy;
    logic [4:0] r_nuse;
    logic [1:0] r_kind;
    logic [BLOCK_BITS-1:0] r_blk;
    logic [NW-1:0] r_i;
    logic [CW-1:0] r_steps;
    logic [FW-1:0] r_hand;
    logic r_found;
    logic [FW-1:0] r_f;
    logic [FW-1:0] r_limit;
    logic [FW-1:0] r_best_age;
    logic r_has_best;
    logic r_ev;
    logic [BLOCK_BITS-1:0] r_evb;
    logic r_evd;
    logic [1:0] r_st;

    logic [NW-1:0] n_act;
    always_comb begin
        if (r_nuse == '0) n_act = NW'(1);
        else if ({27'd0, r_nuse} > 32'(FRAMES)) n_act = NW'(FRAMES);
        else n_act = NW'(r_nuse);
    end

    logic [FW-1:0] t_idx;
    logic t_valid, t_dirty, t_ref, t_we, w_valid, w_dirty, w_ref;
    logic [BLOCK_BITS-1:0] t_block, w_block;
    logic [PIN_W-1:0] t_pin, w_pin;
    logic [FW-1:0] t_age, w_age;

    bfr_frame_table #(.FRAMES(FRAMES), .BLOCK_BITS(BLOCK_BITS)) u_tab (
        .i_clk, .i_rst_n, .i_idx(t_idx),
        .o_valid(t_valid), .o_block(t_block), .o_pin(t_pin), .o_dirty(t_dirty),
        .o_ref(t_ref), .o_age(t_age),
        .i_we(t_we), .i_valid(w_valid), .i_block(w_block), .i_pin(w_pin),
        .i_dirty(w_dirty), .i_ref(w_ref), .i_age(w_age)
    );

    logic [FW-1:0] i_lo;
    assign i_lo = r_i[FW-1:0];
    logic [FW-1:0] hand_next;
    assign hand_next = ({1'b0, r_hand} + NW'(1) < n_act) ? r_hand + FW'(1) : '0;

    logic better;
    always_comb begin
        if (r_policy == POL_MRU) better = t_age < r_best_age;
        else better = t_age > r_best_age;
    end

    assign req.ready = (r_state == S_IDLE);
    assign cfg.ready = 1'b1;
    assign res.valid = (r_state == S_OUT);

    logic [1:0] n_st;
    logic [NW-1:0] n_i;
    always_comb begin
        n_state = r_state;
        n_st = r_st;
        n_i = r_i;
        t_idx = i_lo;
        t_we = 1'b0;
        w_valid = t_valid; w_block = t_block; w_pin = t_pin;
        w_dirty = t_dirty; w_ref = t_ref; w_age = t_age;
        unique case (r_state)
            S_IDLE: begin
                n_i = '0;
                if (req.valid) n_state = S_FIND;
            end
            S_FIND: begin
                if (r_i >= n_act) n_state = S_FIND;
                if (r_found || r_i >= n_act) begin
                    if (r_kind == KIND_NONE || (!r_found && r_kind != KIND_REQ)) begin
                        n_st = ST_ABSENT; n_state = S_OUT;
                    end else if (r_kind == KIND_RELEASE || r_kind == KIND_DIRTY) begin
                        t_idx = r_f; t_we = 1'b1;
                        if (r_kind == KIND_RELEASE) begin
                            if (t_pin != '0) w_pin = t_pin - PIN_W'(1);
                        end else w_dirty = 1'b1;
                        n_st = ST_HIT; n_state = S_OUT;
                    end else if (r_found) begin
                        t_idx = r_f; t_we = 1'b1;
                        if (t_pin != PIN_MAX) w_pin = t_pin + PIN_W'(1);
                        n_st = ST_HIT; n_i = '0; n_state = S_TOUCH;
                    end else begin
                        n_i = '0; n_state = S_FREE;
                    end
                end else n_i = r_i + NW'(1);
            end
            S_FREE: begin
                if (r_i >= n_act) begin
                    n_i = '0;
                    n_state = (r_policy == POL_CLOCK) ? S_CLOCK : S_SCAN;
                end else if (!t_valid) n_state = S_LOAD;
                else n_i = r_i + NW'(1);
            end
            S_SCAN: begin
                if (r_i >= n_act) begin
                    if (r_has_best) begin n_i = '0; n_state = S_DROP; end
                    else begin n_st = ST_PINNED; n_state = S_OUT; end
                end else n_i = r_i + NW'(1);
            end
            S_CLOCK: begin
                t_idx = r_hand;
                if (r_steps >= {n_act, 1'b0}) begin
                    n_st = ST_PINNED; n_state = S_OUT;
                end else if (r_steps == '0 && {1'b0, r_hand} >= n_act) begin
                    n_state = S_CLOCK;
                end else if (t_pin == '0) begin
                    if (!t_ref) begin n_i = '0; n_state = S_DROP; end
                    else begin t_we = 1'b1; w_ref = 1'b0; end
                end
            end
            S_DROP: begin
                if (i_lo != r_f && t_valid && t_age > r_limit && r_i < NW'(FRAMES)) begin
                    t_we = 1'b1; w_age = t_age - FW'(1);
                end
                if (r_i >= NW'(FRAMES - 1)) n_state = S_LOAD;
                else n_i = r_i + NW'(1);
            end
            S_LOAD: begin
                t_idx = r_f; t_we = 1'b1;
                w_valid = 1'b1; w_block = r_blk; w_pin = PIN_W'(1); w_dirty = 1'b0;
                n_st = ST_MISS; n_i = '0; n_state = S_TOUCH;
            end
            S_TOUCH: begin
                t_we = 1'b1;
                if (i_lo == r_f) begin w_age = '0; w_ref = 1'b1; end
                else if (t_valid && t_age < r_limit) w_age = t_age + FW'(1);
                else t_we = 1'b0;
                if (r_i >= NW'(FRAMES - 1)) n_state = S_OUT;
                else n_i = r_i + NW'(1);
            end
            S_OUT: if (res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_policy <= POL_LRU;
            r_nuse <= 5'd16;
            r_hand <= '0;
            r_i <= '0;
            r_st <= ST_HIT;
            r_found <= 1'b0;
            r_has_best <= 1'b0;
            r_ev <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st <= n_st;
            r_i <= n_i;
            if (cfg.valid) begin
                if (cfg.index == REG_POLICY) r_policy <= cfg.data[1:0];
                else r_nuse <= cfg.data;
            end
            unique case (r_state)
                S_IDLE: if (req.valid) begin
                    r_kind <= req.kind; r_blk <= req.block_num;
                    r_found <= 1'b0; r_f <= '0; r_ev <= 1'b0;
                    r_evb <= '0; r_evd <= 1'b0; r_has_best <= 1'b0; r_steps <= '0;
                end
                S_FIND: if (!r_found && r_i < n_act && t_valid && t_block == r_blk) begin
                    r_found <= 1'b1; r_f <= i_lo; r_limit <= t_age;
                end else if (r_found && r_kind == KIND_REQ) r_f <= r_f;
                S_FREE: if (r_i < n_act && !t_valid) r_f <= i_lo;
                S_SCAN: if (r_i < n_act && t_valid && t_pin == '0
                            && (!r_has_best || better)) begin
                    r_has_best <= 1'b1; r_f <= i_lo; r_best_age <= t_age;
                    r_ev <= 1'b1; r_evb <= t_block; r_evd <= t_dirty; r_limit <= t_age;
                end
                S_CLOCK: begin
                    if (r_steps == '0 && {1'b0, r_hand} >= n_act) r_hand <= '0;
                    if (r_steps >= {n_act, 1'b0}) begin
                    end else if (r_steps == '0 && {1'b0, r_hand} >= n_act) begin
                    end else begin
                        r_steps <= r_steps + CW'(1);
                        r_hand <= hand_next;
                        if (t_pin == '0 && !t_ref) begin
                            r_f <= r_hand; r_ev <= 1'b1; r_evb <= t_block;
                            r_evd <= t_dirty; r_limit <= t_age;
                        end
                    end
                end
                S_LOAD: r_limit <= '1;
                default: ;
            endcase
            if (r_state == S_TOUCH && n_state == S_OUT) r_found <= r_found;
        end
    end

    always_comb begin
        res.status = r_st;
        res.frame = '0;
        if (r_st == ST_HIT || r_st == ST_MISS) res.frame = 4'(r_f);
        res.evict_valid = (r_st == ST_MISS) && r_ev;
        res.victim_block = res.evict_valid ? r_evb : '0;
        res.evict_dirty = res.evict_valid && r_evd;
    end
endmodule
`default_nettype wire

@@ sv/bfr_checker.sv @@
// Port-level checker for the buffer frame replacement unit, with its bind
`default_nettype none
`include "buffer_frame_replacement_unit_assert.svh"
module bfr_checker
    import bfr_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_res_valid,
    input wire logic i_res_ready,
    input wire logic [1:0] i_status,
    input wire logic [3:0] i_frame,
    input wire logic i_ev
);
    `BFR_ASSERT_IMP(a_busy, i_clk, i_rst_n, i_res_valid, !i_req_ready)
    `BFR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)
    `BFR_ASSERT_IMP(a_ev, i_clk, i_rst_n, i_res_valid && i_ev, i_status == ST_MISS)
    `BFR_ASSERT_IMP(a_frm, i_clk, i_rst_n, i_res_valid && (i_status == ST_PINNED || i_status == ST_ABSENT), i_frame == 4'd0)
endmodule

bind buffer_frame_replacement_unit bfr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(req.valid), .i_req_ready(req.ready),
    .i_res_valid(res.valid), .i_res_ready(res.ready),
    .i_status(res.status), .i_frame(res.frame), .i_ev(res.evict_valid)
);
`default_nettype wire
